### src/uart_line_framer_core_assert.svh
`ifndef UART_LINE_FRAMER_CORE_ASSERT_SVH
`define UART_LINE_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ULF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ULF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ulf_pkg.sv
package ulf_pkg;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned LenW       = 7;
  localparam int unsigned ByteW      = 8;

  localparam logic [ByteW-1:0] CharLf = 8'h0A;
  localparam logic [ByteW-1:0] CharCr = 8'h0D;

  localparam logic OpByte   = 1'b0;
  localparam logic OpExpire = 1'b1;

  localparam logic EvPayload = 1'b0;
  localparam logic EvReject  = 1'b1;

  localparam logic [1:0] RsnNone    = 2'd0;
  localparam logic [1:0] RsnBareCr  = 2'd1;
  localparam logic [1:0] RsnTooLong = 2'd2;
  localparam logic [1:0] RsnStale   = 2'd3;

  typedef enum logic [1:0] {
    MODE_COLLECT    = 2'd0,
    MODE_PENDING_CR = 2'd1,
    MODE_DISCARD    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_SEND  = 2'd2
  } fsm_e;

  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic             event_kind;
    logic [1:0]       rej_code;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  frame_length;
    logic             last;
  } out_t;

endpackage

### src/ulf_ram.sv
module ulf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/uart_line_framer_core.sv
// Channel  | Direction | Payload | Handshake
// in       | input     | in_t    | in_valid_i / in_stall_o
// out      | output    | out_t   | out_valid_o / out_stall_i
//
// A reject caused by a byte or an expire tick appears on the output the next cycle.
// A completed line is replayed from the line memory with a memory read and then an output
// register load per byte, waiting while the output stalls; no input is taken during the replay.
// Reset clears the mode, the line length and the output valid; the line memory needs no clearing.
// A stall on the output holds the result register and, through it, stalls the input.
module uart_line_framer_core
  import ulf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayload
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  fsm_e            state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] idx_q, idx_d;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic             out_free;
  logic             in_xfer;
  logic             is_last;
  logic             rej;
  logic [1:0]       rej_reason;
  logic             wr_en;
  logic [ByteW-1:0] rd_data;

  ulf_ram #(
    .WIDTH(ByteW),
    .DEPTH(MAX_PAYLOAD)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (len_q[AW-1:0]),
    .wr_data_i (in_data_i.data_byte),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign is_last    = (LenW'(idx_q + 1'b1) == len_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    len_d       = len_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rej         = 1'b0;
    rej_reason  = RsnNone;
    wr_en       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.op == OpExpire) begin
            if (mode_q == MODE_PENDING_CR ||
                (mode_q != MODE_DISCARD && len_q != '0)) begin
              rej        = 1'b1;
              rej_reason = RsnStale;
            end
          end else begin
            case (mode_q)
              MODE_DISCARD: begin
                if (in_data_i.data_byte == CharLf) begin
                  mode_d = MODE_COLLECT;
                  len_d  = '0;
                end
              end
              MODE_PENDING_CR: begin
                if (in_data_i.data_byte == CharLf) begin
                  mode_d = MODE_COLLECT;
                  if (len_q != '0) begin
                    idx_d   = '0;
                    state_d = ST_FETCH;
                  end
                end else begin
                  rej        = 1'b1;
                  rej_reason = RsnBareCr;
                end
              end
              default: begin
                mode_d = MODE_COLLECT;
                if (in_data_i.data_byte == CharLf) begin
                  if (len_q != '0) begin
                    idx_d   = '0;
                    state_d = ST_FETCH;
                  end
                end else if (in_data_i.data_byte == CharCr) begin
                  mode_d = MODE_PENDING_CR;
                end else if (len_q >= LenW'(MAX_PAYLOAD)) begin
                  rej        = 1'b1;
                  rej_reason = RsnTooLong;
                end else begin
                  wr_en = 1'b1;
                  len_d = LenW'(len_q + 1'b1);
                end
              end
            endcase
          end
          if (rej) begin
            out_d.event_kind    = EvReject;
            out_d.rej_code      = rej_reason;
            out_d.payload_byte  = '0;
            out_d.frame_length  = '0;
            out_d.last          = 1'b1;
            out_valid_d         = 1'b1;
            mode_d              = MODE_DISCARD;
            len_d               = '0;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          out_d.event_kind    = EvPayload;
          out_d.rej_code      = RsnNone;
          out_d.payload_byte  = rd_data;
          out_d.frame_length  = len_q;
          out_d.last          = is_last;
          out_valid_d         = 1'b1;
          if (is_last) begin
            len_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = LenW'(idx_q + 1'b1);
            state_d = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_COLLECT;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "uart_line_framer_core_assert.svh"

  `ULF_ASSERT_IMP(a_len_bound, 1'b1, len_q <= LenW'(MAX_PAYLOAD), "Line length above limit.")
  `ULF_ASSERT_IMP(a_replay_nonempty, state_q != ST_IDLE,
                  len_q != '0 && idx_q < len_q, "Replay index out of line.")
  `ULF_ASSERT_NXT(a_last_clears, state_q == ST_SEND && out_free && is_last,
                  len_q == '0 && state_q == ST_IDLE, "Line not cleared after its last byte.")
  `ULF_ASSERT_IMP(a_no_write_busy, state_q != ST_IDLE, !wr_en, "Line memory written during replay.")

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import ulf_pkg::*;

  localparam int HalfPeriod   = 2;
  localparam int ResetCycles  = 6;
  localparam int TotalItems   = 420;
  localparam int QuietItems   = 360;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 2 * MaxPayload + 40;

  localparam logic [1:0] ChkPredict = 2'd0;
  localparam logic [1:0] ChkNone    = 2'd1;
  localparam logic [1:0] ChkReject  = 2'd2;

  typedef struct packed {
    in_t        item;
    logic [6:0] reps;
    logic [1:0] chk;
    logic [1:0] reason;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  bit tx_bursty = 1'b0;
  bit rx_bursty = 1'b0;
  bit hold_req  = 1'b0;
  int mismatches = 0;
  int sent_items = 0;

  mode_e            line_mode = MODE_COLLECT;
  logic [LenW-1:0]  line_len = '0;
  logic [ByteW-1:0] line_buf [MaxPayload];
  out_t             step_events [$];
  out_t             expected_events [$];
  out_t             head_event;
  stim_row_t        dir_rows [$];

  uart_line_framer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #HalfPeriod clk = ~clk;

  function automatic out_t reject_event(input logic [1:0] reason);
    out_t ev;
    ev              = '0;
    ev.event_kind   = EvReject;
    ev.rej_code     = reason;
    ev.last         = 1'b1;
    return ev;
  endfunction

  function void push_reject(input logic [1:0] reason);
    step_events.push_back(reject_event(reason));
    line_mode = MODE_DISCARD;
    line_len  = '0;
  endfunction

  function void push_frame();
    out_t ev;
    int   k;
    for (k = 0; k < line_len; k++) begin
      ev               = '0;
      ev.event_kind    = EvPayload;
      ev.rej_code      = RsnNone;
      ev.payload_byte  = line_buf[k];
      ev.frame_length  = line_len;
      ev.last          = (k + 1 == line_len);
      step_events.push_back(ev);
    end
    line_len  = '0;
    line_mode = MODE_COLLECT;
  endfunction

  function void frame_step(input in_t item);
    step_events.delete();
    if (item.op == OpExpire) begin
      if (line_mode == MODE_PENDING_CR ||
          (line_mode != MODE_DISCARD && line_len != 0)) begin
        push_reject(RsnStale);
      end
    end else if (line_mode == MODE_DISCARD) begin
      if (item.data_byte == CharLf) begin
        line_mode = MODE_COLLECT;
        line_len  = '0;
      end
    end else if (line_mode == MODE_PENDING_CR) begin
      if (item.data_byte == CharLf) begin
        line_mode = MODE_COLLECT;
        if (line_len != 0) push_frame();
      end else begin
        push_reject(RsnBareCr);
      end
    end else if (item.data_byte == CharLf) begin
      if (line_len != 0) push_frame();
    end else if (item.data_byte == CharCr) begin
      line_mode = MODE_PENDING_CR;
    end else if (line_len >= MaxPayload) begin
      push_reject(RsnTooLong);
    end else begin
      line_buf[line_len] = item.data_byte;
      line_len = LenW'(line_len + 1'b1);
    end
  endfunction

  task automatic send_item(input in_t item, input logic [1:0] chk, input logic [1:0] reason);
    int gap;
    if (tx_bursty && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall_o);
    frame_step(item);
    sent_items++;
    if (chk == ChkPredict) begin
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
    end else if (chk == ChkReject) begin
      expected_events.push_back(reject_event(reason));
    end
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    send_item({OpByte, b}, ChkPredict, RsnNone);
  endtask

  task automatic send_expire();
    logic [ByteW-1:0] junk;
    junk = ByteW'($urandom_range(0, 255));
    send_item({OpExpire, junk}, ChkPredict, RsnNone);
  endtask

  function automatic logic [ByteW-1:0] line_char();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(0, 255)); while (b == CharLf || b == CharCr);
    return b;
  endfunction

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  function void add_row(input logic op, input logic [ByteW-1:0] b, input int reps,
                        input logic [1:0] chk, input logic [1:0] reason);
    stim_row_t row;
    row.item   = {op, b};
    row.reps   = 7'(reps);
    row.chk    = chk;
    row.reason = reason;
    dir_rows.push_back(row);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_events.size() == 0) begin
        $display({"%0t: mismatch expected no transfer,",
                  " got kind=%0d reason=%0d byte=%02h len=%0d last=%0d"},
                 $time, out_data_o.event_kind, out_data_o.rej_code,
                 out_data_o.payload_byte, out_data_o.frame_length, out_data_o.last);
        mismatches++;
      end else begin
        head_event = expected_events.pop_front();
        if (out_data_o.event_kind !== head_event.event_kind ||
            out_data_o.rej_code !== head_event.rej_code ||
            out_data_o.payload_byte !== head_event.payload_byte ||
            out_data_o.frame_length !== head_event.frame_length ||
            out_data_o.last !== head_event.last) begin
          $display({"%0t: mismatch expected kind=%0d reason=%0d byte=%02h len=%0d last=%0d,",
                    " got kind=%0d reason=%0d byte=%02h len=%0d last=%0d"}, $time,
                   head_event.event_kind, head_event.rej_code, head_event.payload_byte,
                   head_event.frame_length, head_event.last,
                   out_data_o.event_kind, out_data_o.rej_code, out_data_o.payload_byte,
                   out_data_o.frame_length, out_data_o.last);
          mismatches++;
        end
      end
    end
  end

  initial begin : receiver
    int burst;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_bursty && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int line_no;
    int kind;
    int len;
    int i;

    add_row(OpExpire, 8'hFF, 1, ChkNone, RsnNone);
    add_row(OpByte, CharLf, 1, ChkNone, RsnNone);
    add_row(OpByte, CharCr, 1, ChkNone, RsnNone);
    add_row(OpByte, CharLf, 1, ChkNone, RsnNone);
    add_row(OpByte, 8'h00, 1, ChkNone, RsnNone);
    add_row(OpByte, 8'hFF, 1, ChkNone, RsnNone);
    add_row(OpByte, 8'h41, 1, ChkNone, RsnNone);
    add_row(OpByte, CharLf, 1, ChkPredict, RsnNone);
    add_row(OpByte, 8'h80, 1, ChkNone, RsnNone);
    add_row(OpByte, CharCr, 1, ChkNone, RsnNone);
    add_row(OpByte, CharLf, 1, ChkPredict, RsnNone);
    add_row(OpByte, 8'h55, 1, ChkNone, RsnNone);
    add_row(OpByte, CharCr, 1, ChkNone, RsnNone);
    add_row(OpByte, 8'h42, 1, ChkReject, RsnBareCr);
    add_row(OpByte, 8'h33, 1, ChkNone, RsnNone);
    add_row(OpExpire, 8'h00, 1, ChkNone, RsnNone);
    add_row(OpByte, CharLf, 1, ChkNone, RsnNone);
    add_row(OpByte, CharCr, 1, ChkNone, RsnNone);
    add_row(OpByte, CharCr, 1, ChkReject, RsnBareCr);
    add_row(OpByte, CharLf, 1, ChkNone, RsnNone);
    add_row(OpByte, 8'h7F, 1, ChkNone, RsnNone);
    add_row(OpExpire, CharLf, 1, ChkReject, RsnStale);
    add_row(OpByte, CharLf, 1, ChkNone, RsnNone);
    add_row(OpByte, CharCr, 1, ChkNone, RsnNone);
    add_row(OpExpire, CharCr, 1, ChkReject, RsnStale);
    add_row(OpByte, CharLf, 1, ChkNone, RsnNone);
    add_row(OpByte, 8'hA5, MaxPayload, ChkNone, RsnNone);
    add_row(OpByte, 8'h01, 1, ChkReject, RsnTooLong);
    add_row(OpByte, CharLf, 1, ChkNone, RsnNone);
    add_row(OpByte, 8'h5A, MaxPayload, ChkNone, RsnNone);
    add_row(OpByte, CharLf, 1, ChkPredict, RsnNone);

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_bursty = 1'b1;
    rx_bursty = 1'b1;
    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        send_item(dir_rows[r].item, dir_rows[r].chk, dir_rows[r].reason);
      end
    end
    wait_for_results();

    // Mostly well-formed lines with random content; the rest is broken lines and noise.
    line_no = 0;
    while (sent_items < TotalItems) begin
      if (line_no % 16 == 0) begin
        tx_bursty = ($urandom_range(0, 2) != 0);
        rx_bursty = ($urandom_range(0, 2) != 0);
      end
      if (sent_items >= QuietItems) begin
        tx_bursty = 1'b0;
        rx_bursty = 1'b0;
      end
      if (line_no == 8) hold_req = 1'b1;
      if (line_no == 20) wait_for_results();

      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MaxPayload)
                                          : $urandom_range(0, 12);
        for (i = 0; i < len; i++) send_byte(line_char());
        if ($urandom_range(0, 1) == 1) send_byte(CharCr);
        send_byte(CharLf);
      end else if (kind < 78) begin
        for (i = 0; i <= MaxPayload; i++) send_byte(line_char());
        repeat ($urandom_range(0, 3)) send_byte(line_char());
        send_byte(CharLf);
      end else if (kind < 86) begin
        repeat ($urandom_range(0, 5)) send_byte(line_char());
        send_byte(CharCr);
        send_byte(($urandom_range(0, 3) == 0) ? CharCr : line_char());
        repeat ($urandom_range(0, 3)) send_byte(ByteW'($urandom_range(0, 255)));
        send_byte(CharLf);
      end else if (kind < 94) begin
        repeat ($urandom_range(0, 5)) send_byte(line_char());
        if ($urandom_range(0, 2) == 0) send_byte(CharCr);
        send_expire();
        repeat ($urandom_range(0, 2)) send_expire();
        send_byte(CharLf);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) send_expire();
          else send_byte(ByteW'($urandom_range(0, 255)));
        end
      end
      line_no++;
    end

    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
